@@ rtl/lnff_pkg.sv @@
// ----------------------------------------------------------------------------
// lnff_pkg: shared types and constants for the LCD number field formatter
// Opcodes, controller states, control/status bundles and character codes.
// ----------------------------------------------------------------------------
package lnff_pkg;

  parameter int VALUE_WIDTH_DEF = 16;
  parameter int MAX_DIGITS_DEF  = 16;

  // Field widths fixed by the request format
  parameter int OP_W     = 2;
  parameter int COLUMN_W = 6;
  parameter int COUNT_W  = 5;

  // Display command and character codes
  parameter logic [7:0] CMD_SET_DDRAM = 8'h80;
  parameter logic [6:0] LINE2_OFFSET  = 7'h40;
  parameter logic [6:0] COLUMN_ADJ    = 7'h7F;  // adds -1 modulo 128
  parameter logic [7:0] CH_ZERO       = 8'h30;
  parameter logic [7:0] CH_UPPER_A    = 8'h41;
  parameter logic [7:0] CH_PLUS       = 8'h2B;
  parameter logic [7:0] CH_MINUS      = 8'h2D;
  parameter logic [3:0] DEC_RADIX     = 4'd10;
  parameter logic [3:0] BCD_ADJ_MIN   = 4'd5;
  parameter logic [3:0] BCD_ADJ_ADD   = 4'd3;

  typedef enum logic [OP_W-1:0] {
    OP_UDEC = 2'd0,
    OP_SDEC = 2'd1,
    OP_HEX  = 2'd2,
    OP_BIN  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_CMD,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  typedef enum logic [1:0] {
    EMIT_CMD,
    EMIT_SIGN,
    EMIT_DIGIT
  } emit_e;

  // controller -> datapath
  typedef struct packed {
    logic  load_req;   // capture request fields
    logic  conv_step;  // two double-dabble steps
    logic  out_load;   // load output register
    emit_e emit_sel;   // what byte to load
    logic  out_last;   // final byte of the run
    logic  dig_step;   // one digit consumed
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_signed;
    logic cnt_zero;
    logic rem_one;
    logic out_free;
  } status_t;

endpackage

@@ rtl/lcd_number_field_formatter_core.sv @@
// ----------------------------------------------------------------------------
// lcd_number_field_formatter_core: number to character-display byte stream
// One request becomes a cursor command, an optional sign and the digits.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                        | tuser   | tlast
//  ---------+-----+-------------------------------------------+---------+------------
//  s_axis   | in  | line_select, column, value, digit_count   | opcode  | -
//  m_axis   | out | lcd_byte                                  | is_data | last_of_run
//
//  Each request is accepted, converted, then sent as one cursor beat, one sign
//  beat (signed only) and digit_count digit beats, capped at MAX_DIGITS.
//  The BCD shift loop converts two bits a cycle, and the single output
//  register paces the beats that follow.
//  Reset clears the sequencer and the output valid; no clearing pass.
//  A stalled m_axis holds the current beat; s_axis is ready only when idle,
//  which is also possible while the final beat of a run still waits.
//
module lcd_number_field_formatter_core #(
  parameter int VALUE_WIDTH = lnff_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = lnff_pkg::MAX_DIGITS_DEF,
  parameter int IN_DW       = ((VALUE_WIDTH + 12 + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // {digit_count, value, column, line_select}, line_select at bit 0
  input  logic [IN_DW-1:0]            s_axis_tdata,
  // opcode
  input  logic [lnff_pkg::OP_W-1:0]   s_axis_tuser,
  // display byte channel
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // lcd_byte
  output logic [7:0]                  m_axis_tdata,
  // is_data
  output logic                        m_axis_tuser,
  // last_of_run
  output logic                        m_axis_tlast
);
  import lnff_pkg::*;

  localparam int COL_LO = 1;
  localparam int VAL_LO = COL_LO + COLUMN_W;
  localparam int CNT_LO = VAL_LO + VALUE_WIDTH;

  cmd_t    cmd;
  status_t status;
  op_e     opcode;

  // request fields off the bus
  assign opcode = op_e'(s_axis_tuser);

  lnff_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lnff_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (opcode),
    .line_select_i (s_axis_tdata[0]),
    .column_i      (s_axis_tdata[VAL_LO-1:COL_LO]),
    .value_i       (s_axis_tdata[CNT_LO-1:VAL_LO]),
    .digit_count_i (s_axis_tdata[CNT_LO+COUNT_W-1:CNT_LO]),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_is_data_o (m_axis_tuser),
    .out_byte_o    (m_axis_tdata),
    .out_last_o    (m_axis_tlast)
  );

endmodule

@@ rtl/lnff_ctrl.sv @@
// ----------------------------------------------------------------------------
// lnff_ctrl: sequencer for the LCD number field formatter
// Accepts a request, runs the conversion steps, then paces one beat per byte.
// ----------------------------------------------------------------------------
module lnff_ctrl #(
  parameter int VALUE_WIDTH = lnff_pkg::VALUE_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  lnff_pkg::status_t status_i,
  output lnff_pkg::cmd_t    cmd_o
);
  import lnff_pkg::*;

  localparam int DD_CYC = (VALUE_WIDTH + 1) / 2;
  localparam int CCW    = (DD_CYC > 1) ? $clog2(DD_CYC) : 1;

  state_e         state_q, state_d;
  logic [CCW-1:0] conv_cnt_q, conv_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      conv_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      conv_cnt_q <= conv_cnt_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    conv_cnt_d   = conv_cnt_q;
    req_ready_o  = 1'b0;
    cmd_o        = '0;
    cmd_o.emit_sel = EMIT_CMD;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          conv_cnt_d     = '0;
          state_d        = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        conv_cnt_d      = conv_cnt_q + CCW'(1);
        if (conv_cnt_q == CCW'(DD_CYC - 1)) begin
          state_d = ST_CMD;
        end
      end
      ST_CMD: begin
        cmd_o.emit_sel = EMIT_CMD;
        cmd_o.out_last = !status_i.is_signed && status_i.cnt_zero;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (cmd_o.out_last) begin
            state_d = ST_IDLE;
          end else if (status_i.is_signed) begin
            state_d = ST_SIGN;
          end else begin
            state_d = ST_DIGIT;
          end
        end
      end
      ST_SIGN: begin
        cmd_o.emit_sel = EMIT_SIGN;
        cmd_o.out_last = status_i.cnt_zero;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = status_i.cnt_zero ? ST_IDLE : ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        cmd_o.emit_sel = EMIT_DIGIT;
        cmd_o.out_last = status_i.rem_one;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.dig_step = 1'b1;
          if (status_i.rem_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/lnff_dpath.sv @@
// ----------------------------------------------------------------------------
// lnff_dpath: datapath for the LCD number field formatter
// Operand registers, BCD conversion lanes, digit select and output register.
// ----------------------------------------------------------------------------
module lnff_dpath #(
  parameter int VALUE_WIDTH = lnff_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = lnff_pkg::MAX_DIGITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lnff_pkg::op_e                    opcode_i,
  input  logic                             line_select_i,
  input  logic [lnff_pkg::COLUMN_W-1:0]    column_i,
  input  logic [VALUE_WIDTH-1:0]           value_i,
  input  logic [lnff_pkg::COUNT_W-1:0]     digit_count_i,
  input  lnff_pkg::cmd_t                   cmd_i,
  output lnff_pkg::status_t                status_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             out_is_data_o,
  output logic [7:0]                       out_byte_o,
  output logic                             out_last_o
);
  import lnff_pkg::*;

  localparam int DD_CYC = (VALUE_WIDTH + 1) / 2;
  localparam int SHW    = 2 * DD_CYC;
  localparam int BCD_N  = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int BIW    = $clog2(BCD_N);
  localparam int CW     = $clog2(MAX_DIGITS + 1);
  localparam int SELW   = (CW > BIW) ? CW : BIW;
  localparam int PADW   = VALUE_WIDTH + 4 * MAX_DIGITS;

  op_e                        op_q;
  logic                       line_q;
  logic [COLUMN_W-1:0]        col_q;
  logic [CW-1:0]              cnt_q;
  logic [CW-1:0]              rem_q;
  logic                       neg_q;
  logic [VALUE_WIDTH-1:0]     mag_q;
  logic [SHW-1:0]             sh_q, sh_d;
  logic [BCD_N-1:0][3:0]      bcd_q, bcd_d;

  logic                       neg_in;
  logic [VALUE_WIDTH-1:0]     mag_in;
  logic [CW-1:0]              cnt_in;

  logic                       valid_q;
  logic                       is_data_q, last_q;
  logic [7:0]                 byte_q;

  // operand capture
  always_comb begin
    neg_in = (opcode_i == OP_SDEC) && value_i[VALUE_WIDTH-1];
    mag_in = neg_in ? (~value_i + VALUE_WIDTH'(1)) : value_i;
    cnt_in = (32'(digit_count_i) > MAX_DIGITS) ? CW'(MAX_DIGITS) : CW'(digit_count_i);
  end

  // two double-dabble steps per cycle
  always_comb begin
    logic [BCD_N-1:0][3:0] lane_v;
    logic [SHW-1:0]        sh_v;
    lane_v = bcd_q;
    sh_v   = sh_q;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < BCD_N; k++) begin
        if (lane_v[k] >= BCD_ADJ_MIN) begin
          lane_v[k] = lane_v[k] + BCD_ADJ_ADD;
        end
      end
      for (int k = BCD_N - 1; k > 0; k--) begin
        lane_v[k] = {lane_v[k][2:0], lane_v[k-1][3]};
      end
      lane_v[0] = {lane_v[0][2:0], sh_v[SHW-1]};
      sh_v      = sh_v << 1;
    end
    bcd_d = lane_v;
    sh_d  = sh_v;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q   <= opcode_i;
      line_q <= line_select_i;
      col_q  <= column_i;
      cnt_q  <= cnt_in;
      rem_q  <= cnt_in;
      neg_q  <= neg_in;
      mag_q  <= mag_in;
      sh_q   <= SHW'(mag_in);
      bcd_q  <= '0;
    end else begin
      if (cmd_i.conv_step) begin
        sh_q  <= sh_d;
        bcd_q <= bcd_d;
      end
      if (cmd_i.dig_step) begin
        rem_q <= rem_q - CW'(1);
      end
    end
  end

  // digit select, most significant position first
  logic [SELW-1:0] pos;
  logic [PADW-1:0] hex_sh, bin_sh;
  logic [3:0]      dig;
  logic [7:0]      dig_char;
  logic [6:0]      addr;
  logic [7:0]      sel_byte;

  always_comb begin
    pos    = SELW'(rem_q) - SELW'(1);
    hex_sh = PADW'(mag_q) >> {pos, 2'b00};
    bin_sh = PADW'(mag_q) >> pos;
    case (op_q)
      OP_HEX:  dig = hex_sh[3:0];
      OP_BIN:  dig = {3'b000, bin_sh[0]};
      default: dig = (32'(pos) < BCD_N) ? bcd_q[pos[BIW-1:0]] : 4'd0;
    endcase
    dig_char = (dig < DEC_RADIX) ? (CH_ZERO + {4'b0000, dig})
                                 : (CH_UPPER_A + {4'b0000, dig} - {4'b0000, DEC_RADIX});
    addr = 7'(col_q) + COLUMN_ADJ + (line_q ? LINE2_OFFSET : 7'd0);
    case (cmd_i.emit_sel)
      EMIT_CMD:   sel_byte = CMD_SET_DDRAM | {1'b0, addr};
      EMIT_SIGN:  sel_byte = neg_q ? CH_MINUS : CH_PLUS;
      EMIT_DIGIT: sel_byte = dig_char;
      default:    sel_byte = dig_char;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      byte_q    <= sel_byte;
      is_data_q <= (cmd_i.emit_sel != EMIT_CMD);
      last_q    <= cmd_i.out_last;
    end
  end

  assign status_o.is_signed = (op_q == OP_SDEC);
  assign status_o.cnt_zero  = (cnt_q == '0);
  assign status_o.rem_one   = (rem_q == CW'(1));
  assign status_o.out_free  = !valid_q || out_ready_i;

  assign out_valid_o   = valid_q;
  assign out_is_data_o = is_data_q;
  assign out_byte_o    = byte_q;
  assign out_last_o    = last_q;

endmodule
